// ===== sv/tzr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the triangle fragment stage.
// No dependencies; every other file except tzr_ram refers to this package by scoped names.
package tzr_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SHADE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;   // reserved, ignored

    // Configuration register indexes.
    localparam logic [2:0] CFG_BASE_RED   = 3'd0;
    localparam logic [2:0] CFG_BASE_GREEN = 3'd1;
    localparam logic [2:0] CFG_BASE_BLUE  = 3'd2;
    localparam logic [2:0] CFG_LIGHT_X    = 3'd3;
    localparam logic [2:0] CFG_LIGHT_Y    = 3'd4;
    localparam logic [2:0] CFG_LIGHT_Z    = 3'd5;
    localparam logic [2:0] CFG_AMBIENT    = 3'd6;
    localparam logic [2:0] CFG_GAIN       = 3'd7;

    // Configuration reset values.
    localparam logic [7:0]        RST_BASE_RED   = 8'd180;
    localparam logic [7:0]        RST_BASE_GREEN = 8'd180;
    localparam logic [7:0]        RST_BASE_BLUE  = 8'd60;
    localparam logic signed [15:0] RST_LIGHT_X   = -16'sd8233;
    localparam logic signed [15:0] RST_LIGHT_Y   = 16'sd11526;
    localparam logic signed [15:0] RST_LIGHT_Z   = -16'sd8233;
    localparam logic [8:0]        RST_AMBIENT    = 9'd51;
    localparam logic [8:0]        RST_GAIN       = 9'd205;

    // Interpolated attributes, in processing order.
    localparam logic [1:0] ATTR_DEPTH = 2'd0;
    localparam logic [1:0] ATTR_NX    = 2'd1;
    localparam logic [1:0] ATTR_NY    = 2'd2;
    localparam logic [1:0] ATTR_NZ    = 2'd3;

    localparam logic signed [15:0] DEPTH_MAX = 16'sd32767;
    localparam logic [8:0]         INTEN_ONE = 9'd256;

    // Datapath widths.
    localparam int EDGE_W = 17;   // vertex differences
    localparam int DP_W   = 18;   // pixel center minus vertex 0
    localparam int PROD_W = 36;   // edge cross products
    localparam int W_W    = 40;   // area term and weights
    localparam int IP_W   = 56;   // weighted attribute sums
    localparam int DIV_W  = 56;   // divider numerator and shifted divisor
    localparam int QUOT_W = 18;   // widest quotient
    localparam int CNT_W  = 5;
    localparam int SQ_IN_W  = 48;
    localparam int SQ_OUT_W = 24;

    localparam logic [CNT_W-1:0] QBITS_INTERP = 5'd16;
    localparam logic [CNT_W-1:0] QBITS_DIFF   = 5'd18;
    localparam logic [CNT_W-1:0] SQ_STEPS     = 5'd24;
    localparam logic [SQ_IN_W-1:0] SQ_BIT0    = 48'h4000_0000_0000;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_WSUB,
        ST_W0,
        ST_SIGN,
        ST_TEST,
        ST_IMUL,
        ST_ISUM,
        ST_IDIV,
        ST_DOT,
        ST_DSUM,
        ST_SQ0,
        ST_SQRT,
        ST_DDIV,
        ST_GAIN,
        ST_INTEN,
        ST_COLOR
    } t_state;

    // Start request to the shared divider; den is already shifted up by bits-1.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        logic [CNT_W-1:0] bits;
    } t_div_req;

endpackage

// ===== sv/tzr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read.
// No dependencies.
module tzr_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tzr_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tzr_pkg for widths and the request struct.
module tzr_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tzr_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [tzr_pkg::QUOT_W-1:0] o_quot
);

    logic                        r_busy;
    logic                        r_done;
    logic [tzr_pkg::DIV_W-1:0]   r_rem;
    logic [tzr_pkg::DIV_W-1:0]   r_den;
    logic [tzr_pkg::CNT_W-1:0]   r_cnt;
    logic [tzr_pkg::QUOT_W-1:0]  r_quot;
    logic                        ge;

    assign ge = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == tzr_pkg::CNT_W'(1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_cnt  <= i_req.bits;
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_den;
            end
            r_quot <= {r_quot[tzr_pkg::QUOT_W-2:0], ge};
            r_den  <= r_den >> 1;
            r_cnt  <= r_cnt - tzr_pkg::CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/tzr_isqrt.sv =====
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
// Depends on tzr_pkg for widths and the starting bit.
module tzr_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tzr_pkg::SQ_IN_W-1:0]  i_value,
    output logic                         o_done,
    output logic [tzr_pkg::SQ_OUT_W-1:0] o_root
);

    logic                        r_busy;
    logic                        r_done;
    logic [tzr_pkg::SQ_IN_W-1:0] r_v;
    logic [tzr_pkg::SQ_IN_W-1:0] r_r;
    logic [tzr_pkg::SQ_IN_W-1:0] r_bit;
    logic [tzr_pkg::CNT_W-1:0]   r_cnt;
    logic [tzr_pkg::SQ_IN_W-1:0] trial;
    logic                        ge;

    assign trial = r_r + r_bit;
    assign ge    = (r_v >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == tzr_pkg::CNT_W'(1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= tzr_pkg::SQ_BIT0;
            r_cnt <= tzr_pkg::SQ_STEPS;
        end else if (r_busy) begin
            if (ge) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - tzr_pkg::CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[tzr_pkg::SQ_OUT_W-1:0];

endmodule

// ===== sv/triangle_zbuffer_shaded_raster.sv =====
`timescale 1ns / 1ps
// Triangle fragment stage: barycentric coverage, depth store, diffuse shading.
// Depends on tzr_pkg, tzr_ram, tzr_div and tzr_isqrt.
//
//   channel   handshake                  payload
//   -------   -------------------------  ----------------------------------------
//   input     i_valid / o_stall          i_opcode .. i_pixel_row (one request)
//   output    o_valid / i_stall          o_out_col, o_out_row, o_red/green/blue
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Loads and clears finish without leaving the idle state. A covered, visible,
// lit pixel makes four attribute divisions of 16 steps each on the shared
// divider, a 24 step square root and an 18 step division. Rejected pixels
// leave early. After reset a sweep writes the maximum depth into all
// SCREEN_COLS*SCREEN_ROWS depth entries, one per cycle, with o_stall high;
// configuration writes are taken during the sweep. A waiting result does not
// block the next request; only the final color load waits on i_stall.
module triangle_zbuffer_shaded_raster #(
    parameter int SCREEN_COLS = 512,
    parameter int SCREEN_ROWS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_vertex_slot,
    input  logic signed [15:0] i_vert_x,
    input  logic signed [15:0] i_vert_y,
    input  logic signed [15:0] i_vert_depth,
    input  logic signed [15:0] i_norm_x,
    input  logic signed [15:0] i_norm_y,
    input  logic signed [15:0] i_norm_z,
    input  logic [8:0]         i_pixel_col,
    input  logic [7:0]         i_pixel_row,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [8:0]         o_out_col,
    output logic [7:0]         o_out_row,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int DEPTH  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int EDGE_W = tzr_pkg::EDGE_W;
    localparam int DP_W   = tzr_pkg::DP_W;
    localparam int PROD_W = tzr_pkg::PROD_W;
    localparam int W_W    = tzr_pkg::W_W;
    localparam int IP_W   = tzr_pkg::IP_W;
    localparam int DIV_W  = tzr_pkg::DIV_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0]         r_base_red;
    logic [7:0]         r_base_green;
    logic [7:0]         r_base_blue;
    logic signed [15:0] r_light_x;
    logic signed [15:0] r_light_y;
    logic signed [15:0] r_light_z;
    logic [8:0]         r_ambient;
    logic [8:0]         r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_red   <= tzr_pkg::RST_BASE_RED;
            r_base_green <= tzr_pkg::RST_BASE_GREEN;
            r_base_blue  <= tzr_pkg::RST_BASE_BLUE;
            r_light_x    <= tzr_pkg::RST_LIGHT_X;
            r_light_y    <= tzr_pkg::RST_LIGHT_Y;
            r_light_z    <= tzr_pkg::RST_LIGHT_Z;
            r_ambient    <= tzr_pkg::RST_AMBIENT;
            r_gain       <= tzr_pkg::RST_GAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tzr_pkg::CFG_BASE_RED:   r_base_red   <= i_cfg_data[7:0];
                tzr_pkg::CFG_BASE_GREEN: r_base_green <= i_cfg_data[7:0];
                tzr_pkg::CFG_BASE_BLUE:  r_base_blue  <= i_cfg_data[7:0];
                tzr_pkg::CFG_LIGHT_X:    r_light_x    <= signed'(i_cfg_data);
                tzr_pkg::CFG_LIGHT_Y:    r_light_y    <= signed'(i_cfg_data);
                tzr_pkg::CFG_LIGHT_Z:    r_light_z    <= signed'(i_cfg_data);
                tzr_pkg::CFG_AMBIENT:    r_ambient    <= i_cfg_data[8:0];
                tzr_pkg::CFG_GAIN:       r_gain       <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Vertex slots: position plus four attributes (depth, normal x/y/z)
    // ---------------------------------------------------------------
    logic signed [15:0] r_slot_x    [3];
    logic signed [15:0] r_slot_y    [3];
    logic signed [15:0] r_slot_attr [4][3];

    // ---------------------------------------------------------------
    // Control and datapath state
    // ---------------------------------------------------------------
    tzr_pkg::t_state r_state, n_state;

    logic              in_acc;
    logic              on_screen;
    logic [ADDR_W-1:0] in_idx;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_idx;
    logic [8:0]        r_col;
    logic [7:0]        r_row;

    logic signed [EDGE_W-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [DP_W-1:0]   r_dpx, r_dpy;
    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf;
    logic signed [W_W-1:0]    r_d, r_w0, r_w1, r_w2;
    logic signed [15:0]       r_zold;
    logic [1:0]               r_k;
    logic signed [IP_W-1:0]   r_m0, r_m1, r_m2;
    logic signed [IP_W-1:0]   isum;
    logic signed [15:0]       r_attr [4];
    logic signed [15:0]       z_new;

    logic signed [31:0] r_q0, r_q1, r_q2, r_s0, r_s1, r_s2;
    logic signed [33:0] r_dot;
    logic [31:0]        r_s;
    logic [tzr_pkg::QUOT_W-1:0] r_diff;
    logic [26:0]        r_gd;
    logic [13:0]        inten_sum;
    logic [8:0]         r_inten;
    logic [16:0]        prod_r, prod_g, prod_b;

    logic               r_out_valid;
    logic               out_free;

    // memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;

    // shared arithmetic units
    tzr_pkg::t_div_req            div_req;
    logic                         div_done;
    logic [tzr_pkg::QUOT_W-1:0]   div_quot;
    logic                         sq_start;
    logic [tzr_pkg::SQ_IN_W-1:0]  sq_value;
    logic                         sq_done;
    logic [tzr_pkg::SQ_OUT_W-1:0] sq_root;

    tzr_ram #(
        .DATA_W (16),
        .DEPTH  (DEPTH)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    tzr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    tzr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    assign o_stall   = (r_state != tzr_pkg::ST_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign on_screen = (int'(i_pixel_col) < SCREEN_COLS) &&
                       (int'(i_pixel_row) < SCREEN_ROWS);
    assign in_idx    = ADDR_W'(i_pixel_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(i_pixel_col);

    // Weighted sum offset by 2^15 * area so the quotient is never negative;
    // flipping the top bit of the 16-bit quotient then gives the floor.
    assign isum  = r_m0 + r_m1 + r_m2 + (IP_W'(r_d) <<< 15);
    assign z_new = signed'(div_quot[15:0] ^ 16'h8000);

    assign out_free  = !r_out_valid || !i_stall;
    assign inten_sum = 14'(r_ambient) + 14'(r_gd[26:14]);
    assign prod_r    = 17'(r_base_red)   * 17'(r_inten);
    assign prod_g    = 17'(r_base_green) * 17'(r_inten);
    assign prod_b    = 17'(r_base_blue)  * 17'(r_inten);
    assign sq_value  = {r_s, 16'b0};

    // ---------------------------------------------------------------
    // State register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tzr_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Next state, memory port and unit starts
    // ---------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = in_idx;
        ram_wdata = tzr_pkg::DEPTH_MAX;
        div_req   = '0;
        sq_start  = 1'b0;
        unique case (r_state)
            tzr_pkg::ST_CLEAR: begin
                // sweep the store to maximum depth after reset
                ram_we   = 1'b1;
                ram_addr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = tzr_pkg::ST_IDLE;
                end
            end
            tzr_pkg::ST_IDLE: begin
                // read the stored depth now for a shade request
                if (in_acc) begin
                    case (i_opcode)
                        tzr_pkg::OP_CLEAR: ram_we = on_screen;
                        tzr_pkg::OP_SHADE: begin
                            if (on_screen) begin
                                n_state = tzr_pkg::ST_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tzr_pkg::ST_MUL:  n_state = tzr_pkg::ST_WSUB;
            tzr_pkg::ST_WSUB: n_state = tzr_pkg::ST_W0;
            tzr_pkg::ST_W0:   n_state = tzr_pkg::ST_SIGN;
            tzr_pkg::ST_SIGN: begin
                // drop degenerate triangles
                n_state = (r_d == '0) ? tzr_pkg::ST_IDLE : tzr_pkg::ST_TEST;
            end
            tzr_pkg::ST_TEST: begin
                // drop pixels outside the triangle
                if (r_w0 < 0 || r_w1 < 0 || r_w2 < 0) begin
                    n_state = tzr_pkg::ST_IDLE;
                end else begin
                    n_state = tzr_pkg::ST_IMUL;
                end
            end
            tzr_pkg::ST_IMUL: n_state = tzr_pkg::ST_ISUM;
            tzr_pkg::ST_ISUM: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_W'(unsigned'(isum));
                div_req.den   = DIV_W'({r_d, 15'b0});
                div_req.bits  = tzr_pkg::QBITS_INTERP;
                n_state       = tzr_pkg::ST_IDIV;
            end
            tzr_pkg::ST_IDIV: begin
                if (div_done) begin
                    if (r_k == tzr_pkg::ATTR_DEPTH) begin
                        // depth test against the value read on accept
                        if (z_new < r_zold) begin
                            ram_we    = 1'b1;
                            ram_addr  = r_idx;
                            ram_wdata = z_new;
                            n_state   = tzr_pkg::ST_IMUL;
                        end else begin
                            n_state = tzr_pkg::ST_IDLE;
                        end
                    end else if (r_k == tzr_pkg::ATTR_NZ) begin
                        n_state = tzr_pkg::ST_DOT;
                    end else begin
                        n_state = tzr_pkg::ST_IMUL;
                    end
                end
            end
            tzr_pkg::ST_DOT:  n_state = tzr_pkg::ST_DSUM;
            tzr_pkg::ST_DSUM: n_state = tzr_pkg::ST_SQ0;
            tzr_pkg::ST_SQ0: begin
                // skip the root for a zero normal or a back-lit pixel
                if (r_s == '0 || r_dot <= 34'sd0) begin
                    n_state = tzr_pkg::ST_GAIN;
                end else begin
                    sq_start = 1'b1;
                    n_state  = tzr_pkg::ST_SQRT;
                end
            end
            tzr_pkg::ST_SQRT: begin
                if (sq_done) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'({r_dot, 8'b0});
                    div_req.den   = DIV_W'({sq_root, 17'b0});
                    div_req.bits  = tzr_pkg::QBITS_DIFF;
                    n_state       = tzr_pkg::ST_DDIV;
                end
            end
            tzr_pkg::ST_DDIV: begin
                if (div_done) begin
                    n_state = tzr_pkg::ST_GAIN;
                end
            end
            tzr_pkg::ST_GAIN:  n_state = tzr_pkg::ST_INTEN;
            tzr_pkg::ST_INTEN: n_state = tzr_pkg::ST_COLOR;
            tzr_pkg::ST_COLOR: begin
                // hold until the result register is free
                if (out_free) begin
                    n_state = tzr_pkg::ST_IDLE;
                end
            end
            default: n_state = tzr_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Slots and clear sweep counter (reset state)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            for (int s = 0; s < 3; s++) begin
                r_slot_x[s] <= '0;
                r_slot_y[s] <= '0;
                for (int a = 0; a < 4; a++) begin
                    r_slot_attr[a][s] <= '0;
                end
            end
        end else begin
            if (r_state == tzr_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            // drop loads aimed at the unused fourth slot
            if (in_acc && i_opcode == tzr_pkg::OP_LOAD && i_vertex_slot != 2'd3) begin
                r_slot_x[i_vertex_slot]                       <= i_vert_x;
                r_slot_y[i_vertex_slot]                       <= i_vert_y;
                r_slot_attr[tzr_pkg::ATTR_DEPTH][i_vertex_slot] <= i_vert_depth;
                r_slot_attr[tzr_pkg::ATTR_NX][i_vertex_slot]    <= i_norm_x;
                r_slot_attr[tzr_pkg::ATTR_NY][i_vertex_slot]    <= i_norm_y;
                r_slot_attr[tzr_pkg::ATTR_NZ][i_vertex_slot]    <= i_norm_z;
            end
        end
    end

    // ---------------------------------------------------------------
    // Shading datapath
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            tzr_pkg::ST_IDLE: begin
                r_idx <= in_idx;
                r_col <= i_pixel_col;
                r_row <= i_pixel_row;
                r_e1x <= EDGE_W'(r_slot_x[1]) - EDGE_W'(r_slot_x[0]);
                r_e1y <= EDGE_W'(r_slot_y[1]) - EDGE_W'(r_slot_y[0]);
                r_e2x <= EDGE_W'(r_slot_x[2]) - EDGE_W'(r_slot_x[0]);
                r_e2y <= EDGE_W'(r_slot_y[2]) - EDGE_W'(r_slot_y[0]);
                r_dpx <= DP_W'(signed'({1'b0, i_pixel_col, 4'd8})) - DP_W'(r_slot_x[0]);
                r_dpy <= DP_W'(signed'({1'b0, i_pixel_row, 4'd8})) - DP_W'(r_slot_y[0]);
            end
            tzr_pkg::ST_MUL: begin
                r_zold <= signed'(ram_rdata);
                r_pa   <= PROD_W'(r_e1x) * PROD_W'(r_e2y);
                r_pb   <= PROD_W'(r_e2x) * PROD_W'(r_e1y);
                r_pc   <= PROD_W'(r_dpx) * PROD_W'(r_e2y);
                r_pd   <= PROD_W'(r_e2x) * PROD_W'(r_dpy);
                r_pe   <= PROD_W'(r_e1x) * PROD_W'(r_dpy);
                r_pf   <= PROD_W'(r_dpx) * PROD_W'(r_e1y);
            end
            tzr_pkg::ST_WSUB: begin
                r_d  <= W_W'(r_pa) - W_W'(r_pb);
                r_w1 <= W_W'(r_pc) - W_W'(r_pd);
                r_w2 <= W_W'(r_pe) - W_W'(r_pf);
            end
            tzr_pkg::ST_W0: begin
                r_w0 <= r_d - r_w1 - r_w2;
            end
            tzr_pkg::ST_SIGN: begin
                // flip a clockwise triangle so the area term is positive
                if (r_d < 0) begin
                    r_d  <= -r_d;
                    r_w0 <= -r_w0;
                    r_w1 <= -r_w1;
                    r_w2 <= -r_w2;
                end
            end
            tzr_pkg::ST_TEST: begin
                r_k <= tzr_pkg::ATTR_DEPTH;
            end
            tzr_pkg::ST_IMUL: begin
                r_m0 <= IP_W'(r_w0) * IP_W'(r_slot_attr[r_k][0]);
                r_m1 <= IP_W'(r_w1) * IP_W'(r_slot_attr[r_k][1]);
                r_m2 <= IP_W'(r_w2) * IP_W'(r_slot_attr[r_k][2]);
            end
            tzr_pkg::ST_IDIV: begin
                if (div_done) begin
                    r_attr[r_k] <= z_new;
                    r_k         <= r_k + 2'd1;
                end
            end
            tzr_pkg::ST_DOT: begin
                r_q0 <= 32'(r_attr[tzr_pkg::ATTR_NX]) * 32'(r_light_x);
                r_q1 <= 32'(r_attr[tzr_pkg::ATTR_NY]) * 32'(r_light_y);
                r_q2 <= 32'(r_attr[tzr_pkg::ATTR_NZ]) * 32'(r_light_z);
                r_s0 <= 32'(r_attr[tzr_pkg::ATTR_NX]) * 32'(r_attr[tzr_pkg::ATTR_NX]);
                r_s1 <= 32'(r_attr[tzr_pkg::ATTR_NY]) * 32'(r_attr[tzr_pkg::ATTR_NY]);
                r_s2 <= 32'(r_attr[tzr_pkg::ATTR_NZ]) * 32'(r_attr[tzr_pkg::ATTR_NZ]);
            end
            tzr_pkg::ST_DSUM: begin
                r_dot <= 34'(r_q0) + 34'(r_q1) + 34'(r_q2);
                r_s   <= unsigned'(r_s0) + unsigned'(r_s1) + unsigned'(r_s2);
            end
            tzr_pkg::ST_SQ0: begin
                r_diff <= '0;
            end
            tzr_pkg::ST_DDIV: begin
                if (div_done) begin
                    r_diff <= div_quot;
                end
            end
            tzr_pkg::ST_GAIN: begin
                r_gd <= 27'(r_gain) * 27'(r_diff);
            end
            tzr_pkg::ST_INTEN: begin
                r_inten <= (inten_sum > 14'(tzr_pkg::INTEN_ONE)) ? tzr_pkg::INTEN_ONE
                                                                 : inten_sum[8:0];
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tzr_pkg::ST_COLOR && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tzr_pkg::ST_COLOR && out_free) begin
            o_out_col <= r_col;
            o_out_row <= r_row;
            o_red     <= prod_r[15:8];
            o_green   <= prod_g[15:8];
            o_blue    <= prod_b[15:8];
        end
    end

    assign o_valid = r_out_valid;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A new result only appears from the color step.
    a_result_from_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == tzr_pkg::ST_COLOR))
        else $error("result raised outside the color step");

    // A passing depth write goes on to the first normal component.
    a_depth_write_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == tzr_pkg::ST_IDIV) |=>
            (r_state == tzr_pkg::ST_IMUL && r_k == tzr_pkg::ATTR_NX))
        else $error("depth write not followed by normal interpolation");

    // The root runs only for a nonzero normal facing the light.
    a_sqrt_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tzr_pkg::ST_SQRT) |-> (r_s != '0 && r_dot > 34'sd0))
        else $error("square root entered with a zero normal or no light");

endmodule

// ===== tb/tb_triangle_zbuffer_shaded_raster.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the triangle fragment stage: an in-bench depth store and
// shading predictor check every written pixel. Depends on tzr_pkg and the RTL top level.
module tb_triangle_zbuffer_shaded_raster;

    localparam int COLS        = 512;
    localparam int ROWS        = 256;
    localparam int SETTLE      = 200;        // cycles past the slowest pixel
    localparam int CYCLE_LIMIT = 2_000_000;  // clear sweep plus every item at its slowest

    typedef struct {
        logic [8:0] col;
        logic [7:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_opcode;
    logic [1:0]         i_vertex_slot;
    logic signed [15:0] i_vert_x;
    logic signed [15:0] i_vert_y;
    logic signed [15:0] i_vert_depth;
    logic signed [15:0] i_norm_x;
    logic signed [15:0] i_norm_y;
    logic signed [15:0] i_norm_z;
    logic [8:0]         i_pixel_col;
    logic [7:0]         i_pixel_row;
    logic               o_valid;
    logic               i_stall;
    logic [8:0]         o_out_col;
    logic [7:0]         o_out_row;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    triangle_zbuffer_shaded_raster #(.SCREEN_COLS(COLS), .SCREEN_ROWS(ROWS)) DUT (.*);

    // Predictor state: triangle slots, shading registers and the depth store.
    logic signed [15:0] vx_slot [3];
    logic signed [15:0] vy_slot [3];
    logic signed [15:0] vz_slot [3];
    logic signed [15:0] nx_slot [3];
    logic signed [15:0] ny_slot [3];
    logic signed [15:0] nz_slot [3];
    logic [7:0]         base_r, base_g, base_b;
    logic signed [15:0] light_x, light_y, light_z;
    logic [8:0]         ambient, gain;
    shortint            depth_map [COLS*ROWS];

    t_pixel pending_pixels [$];
    int     errors;
    int     cycles;
    int     hold_cycles;   // long receiver hold-off, counted down by the stall process
    bit     quiet;         // no idling on either side while set

    // Clock; the single reset at the start of the run is driven by the main process.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Floor division for a positive divisor.
    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q -= 1;
        return q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Work out the pixel a shade request writes, if any, and update the depth map.
    function automatic void predict_shade(logic [8:0] col, logic [7:0] row);
        longint e1x, e1y, e2x, e2y, dpx, dpy, d, w0, w1, w2, z, nx, ny, nz, dot;
        longint unsigned s, mag, diff, inten;
        int     idx;
        t_pixel px;
        idx = int'(row) * COLS + int'(col);
        e1x = longint'(vx_slot[1]) - vx_slot[0];
        e1y = longint'(vy_slot[1]) - vy_slot[0];
        e2x = longint'(vx_slot[2]) - vx_slot[0];
        e2y = longint'(vy_slot[2]) - vy_slot[0];
        dpx = longint'(col) * 16 + 8 - vx_slot[0];
        dpy = longint'(row) * 16 + 8 - vy_slot[0];
        d = e1x * e2y - e2x * e1y;
        if (d == 0) return;
        w1 = dpx * e2y - e2x * dpy;
        w2 = e1x * dpy - dpx * e1y;
        w0 = d - w1 - w2;
        if (d < 0) begin
            d = -d; w0 = -w0; w1 = -w1; w2 = -w2;
        end
        if (w0 < 0 || w1 < 0 || w2 < 0) return;
        z = floor_div(w0 * vz_slot[0] + w1 * vz_slot[1] + w2 * vz_slot[2], d);
        if (z >= depth_map[idx]) return;
        depth_map[idx] = shortint'(z);
        nx = floor_div(w0 * nx_slot[0] + w1 * nx_slot[1] + w2 * nx_slot[2], d);
        ny = floor_div(w0 * ny_slot[0] + w1 * ny_slot[1] + w2 * ny_slot[2], d);
        nz = floor_div(w0 * nz_slot[0] + w1 * nz_slot[1] + w2 * nz_slot[2], d);
        dot = nx * light_x + ny * light_y + nz * light_z;
        s = nx * nx + ny * ny + nz * nz;
        diff = 0;
        if (s != 0 && dot > 0) begin
            mag = int_sqrt(s << 16);
            diff = (longint'(dot) << 8) / mag;
        end
        inten = longint'(ambient) + ((longint'(gain) * diff) >> 14);
        if (inten > 256) inten = 256;
        px.col   = col;
        px.row   = row;
        px.red   = 8'((longint'(base_r) * inten) >> 8);
        px.green = 8'((longint'(base_g) * inten) >> 8);
        px.blue  = 8'((longint'(base_b) * inten) >> 8);
        pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    // Drive one request, hold it until accepted, then advance the predictor.
    task automatic send_request(logic [1:0] op, logic [1:0] slot,
                                logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                                logic [8:0] col, logic [7:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_vertex_slot <= slot;
        i_vert_x      <= x;
        i_vert_y      <= y;
        i_vert_depth  <= z;
        i_norm_x      <= nx;
        i_norm_y      <= ny;
        i_norm_z      <= nz;
        i_pixel_col   <= col;
        i_pixel_row   <= row;
        do @(posedge i_clk); while (o_stall);
        if (op == tzr_pkg::OP_LOAD && slot < 3) begin
            vx_slot[slot] = x;  vy_slot[slot] = y;  vz_slot[slot] = z;
            nx_slot[slot] = nx; ny_slot[slot] = ny; nz_slot[slot] = nz;
        end else if (op == tzr_pkg::OP_CLEAR) begin
            depth_map[int'(row) * COLS + int'(col)] = tzr_pkg::DEPTH_MAX;
        end else if (op == tzr_pkg::OP_SHADE) begin
            predict_shade(col, row);
        end
    endtask

    task automatic load_vertex(logic [1:0] slot, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, logic [15:0] nx, logic [15:0] ny,
                               logic [15:0] nz);
        send_request(tzr_pkg::OP_LOAD, slot, x, y, z, nx, ny, nz,
                     9'($urandom), 8'($urandom));
    endtask

    // Shade and clear carry random filler in the unused vertex fields.
    task automatic pixel_request(logic [1:0] op, logic [8:0] col, logic [7:0] row);
        send_request(op, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), col, row);
    endtask

    // Lower valid and wait out every expected pixel, then the slowest rejected one.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            tzr_pkg::CFG_BASE_RED:   base_r  = data[7:0];
            tzr_pkg::CFG_BASE_GREEN: base_g  = data[7:0];
            tzr_pkg::CFG_BASE_BLUE:  base_b  = data[7:0];
            tzr_pkg::CFG_LIGHT_X:    light_x = data;
            tzr_pkg::CFG_LIGHT_Y:    light_y = data;
            tzr_pkg::CFG_LIGHT_Z:    light_z = data;
            tzr_pkg::CFG_AMBIENT:    ambient = data[8:0];
            default:                 gain    = data[8:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_shading(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 int lx, int ly, int lz, int amb, int gn);
        write_reg(tzr_pkg::CFG_BASE_RED, 16'(r));
        write_reg(tzr_pkg::CFG_BASE_GREEN, 16'(g));
        write_reg(tzr_pkg::CFG_BASE_BLUE, 16'(b));
        write_reg(tzr_pkg::CFG_LIGHT_X, 16'(lx));
        write_reg(tzr_pkg::CFG_LIGHT_Y, 16'(ly));
        write_reg(tzr_pkg::CFG_LIGHT_Z, 16'(lz));
        write_reg(tzr_pkg::CFG_AMBIENT, 16'(amb));
        write_reg(tzr_pkg::CFG_GAIN, 16'(gn));
    endtask

    // Load a small random triangle around pixel (cx, cy); reach varies the size.
    task automatic load_triangle(int cx, int cy, int reach, bit flat_normal);
        int nx, ny, nz;
        nx = $urandom_range(0, 32768) - 16384;
        ny = $urandom_range(0, 32768) - 16384;
        nz = $urandom_range(0, 32768) - 16384;
        for (int k = 0; k < 3; k++) begin
            if (!flat_normal) begin
                nx = $urandom_range(0, 32768) - 16384;
                ny = $urandom_range(0, 32768) - 16384;
                nz = $urandom_range(0, 32768) - 16384;
            end
            load_vertex(2'(k),
                        16'(cx * 16 + $urandom_range(0, 2 * reach * 16) - reach * 16),
                        16'(cy * 16 + $urandom_range(0, 2 * reach * 16) - reach * 16),
                        16'($urandom_range(0, 65535) - 32768),
                        16'(nx), 16'(ny), 16'(nz));
        end
    endtask

    // Result side: random stall, with the long hold-off counted here.
    initial begin
        int run;
        bit level;
        run = 0;
        level = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                if (run == 0) begin
                    level = ($urandom_range(0, 2) == 0);
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(1, 4);
                end
                run--;
                i_stall <= level;
            end
        end
    end

    // Compare every accepted pixel with the oldest expectation.
    initial begin
        t_pixel want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_pixels.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pixel col=%0d row=%0d rgb=%0d,%0d,%0d",
                                 o_out_col, o_out_row, o_red, o_green, o_blue);
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_out_col !== want.col || o_out_row !== want.row ||
                        o_red !== want.red || o_green !== want.green ||
                        o_blue !== want.blue) begin
                        errors++;
                        if (errors <= 10)
                            $display({"pixel mismatch: want %0d,%0d rgb=%0d,%0d,%0d",
                                      " got %0d,%0d rgb=%0d,%0d,%0d"},
                                     want.col, want.row, want.red, want.green,
                                     want.blue, o_out_col, o_out_row, o_red,
                                     o_green, o_blue);
                    end
                end
            end
        end
    end

    // Extremes of every field, every opcode and each named corner case.
    task automatic test_directed();
        load_vertex(2'd0, 16'h8000, 16'h8000, 16'h8000, 16'hC000, 16'hC000, 16'hC000);
        load_vertex(2'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h4000, 16'h4000);
        load_vertex(2'd2, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        pixel_request(tzr_pkg::OP_SHADE, 9'd511, 8'd255);
        pixel_request(tzr_pkg::OP_SHADE, 9'd0, 8'd0);
        // big triangle over the whole screen, two vertex normals toward the light
        load_vertex(2'd0, -16'sd100, -16'sd100, 16'sd100, -16'sd8233, 16'sd11526, -16'sd8233);
        load_vertex(2'd1, 16'sd20000, -16'sd100, 16'sd0, -16'sd8233, 16'sd11526, -16'sd8233);
        load_vertex(2'd2, -16'sd100, 16'sd12000, -16'sd50, 16'sd16384, 16'sd0, 16'sd0);
        pixel_request(tzr_pkg::OP_SHADE, 9'd0, 8'd0);
        pixel_request(tzr_pkg::OP_SHADE, 9'd100, 8'd50);
        pixel_request(tzr_pkg::OP_SHADE, 9'd100, 8'd50);   // depth not nearer
        pixel_request(tzr_pkg::OP_CLEAR, 9'd100, 8'd50);
        pixel_request(tzr_pkg::OP_SHADE, 9'd100, 8'd50);   // visible again after clear
        pixel_request(tzr_pkg::OP_SHADE, 9'd511, 8'd255);  // inside the triangle as well
        pixel_request(tzr_pkg::OP_CLEAR, 9'd511, 8'd255);
        send_request(tzr_pkg::OP_RSVD, 2'd0, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                     9'd10, 8'd10);               // unused opcode
        load_vertex(2'd3, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);  // no such slot
        pixel_request(tzr_pkg::OP_SHADE, 9'd10, 8'd10);
        // zero normal everywhere
        load_vertex(2'd0, 16'sd0, 16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0);
        load_vertex(2'd1, 16'sd4000, 16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0);
        load_vertex(2'd2, 16'sd0, 16'sd4000, -16'sd1000, 16'sd0, 16'sd0, 16'sd0);
        pixel_request(tzr_pkg::OP_SHADE, 9'd20, 8'd20);
        // degenerate: all three on one line
        load_vertex(2'd2, 16'sd8000, 16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0);
        pixel_request(tzr_pkg::OP_SHADE, 9'd30, 8'd0);
        drain();
    endtask

    // Triangles with pixels mostly in their bounding box, plus noise.
    task automatic test_random_scene(int count);
        int sent, cx, cy, reach, r;
        sent = 0;
        while (sent < count) begin
            cx = $urandom_range(0, 511);
            cy = $urandom_range(0, 255);
            reach = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                 : $urandom_range(1, 6);
            load_triangle(cx, cy, reach, $urandom_range(0, 3) == 0);
            sent += 3;
            repeat ($urandom_range(6, 14)) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    pixel_request(tzr_pkg::OP_SHADE,
                                  9'(cx + $urandom_range(0, 2 * reach) - reach),
                                  8'(cy + $urandom_range(0, 2 * reach) - reach));
                end else if (r < 88) begin
                    pixel_request(tzr_pkg::OP_CLEAR,
                                  9'(cx + $urandom_range(0, 2 * reach) - reach),
                                  8'(cy + $urandom_range(0, 2 * reach) - reach));
                end else if (r < 94) begin
                    pixel_request(tzr_pkg::OP_SHADE, 9'($urandom), 8'($urandom));
                end else begin
                    // stray request with a random opcode over a random slot, full-range fields
                    send_request(2'($urandom_range(0, 3)), 2'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 9'($urandom), 8'($urandom));
                end
                sent++;
            end
        end
        drain();
    endtask

    // Run the scene under several shading settings, extremes included.
    task automatic test_shading_settings();
        apply_shading(8'd255, 8'd255, 8'd255, 16384, 0, 0, 0, 256);
        test_random_scene(150);
        apply_shading(8'd0, 8'd128, 8'd255, -16384, -16384, 16384, 256, 0);
        test_random_scene(100);
        apply_shading(8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                      $urandom_range(0, 32768) - 16384,
                      $urandom_range(0, 256), $urandom_range(0, 256));
        test_random_scene(350);
        apply_shading(8'd180, 8'd180, 8'd60, 0, 0, 16384, 128, 256);
        test_random_scene(350);
    endtask

    // Hold the result side off while requests keep coming, then run scenes with and without idling.
    task automatic test_backpressure();
        load_triangle(256, 128, 20, 1'b1);
        hold_cycles = 1500;
        repeat (40)
            pixel_request(tzr_pkg::OP_SHADE, 9'($urandom_range(236, 276)),
                          8'($urandom_range(108, 148)));
        drain();
        quiet = 1'b1;   // a stretch with no idling on either side
        test_random_scene(150);
        quiet = 1'b0;
        test_random_scene(350);
    endtask

    initial begin
        errors        = 0;
        hold_cycles   = 0;
        quiet         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = tzr_pkg::OP_LOAD;
        i_vertex_slot = 2'd0;
        i_vert_x      = '0;
        i_vert_y      = '0;
        i_vert_depth  = '0;
        i_norm_x      = '0;
        i_norm_y      = '0;
        i_norm_z      = '0;
        i_pixel_col   = '0;
        i_pixel_row   = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = tzr_pkg::CFG_BASE_RED;
        i_cfg_data    = '0;
        for (int k = 0; k < 3; k++) begin
            vx_slot[k] = '0; vy_slot[k] = '0; vz_slot[k] = '0;
            nx_slot[k] = '0; ny_slot[k] = '0; nz_slot[k] = '0;
        end
        foreach (depth_map[k]) depth_map[k] = tzr_pkg::DEPTH_MAX;
        base_r  = tzr_pkg::RST_BASE_RED;
        base_g  = tzr_pkg::RST_BASE_GREEN;
        base_b  = tzr_pkg::RST_BASE_BLUE;
        light_x = tzr_pkg::RST_LIGHT_X;
        light_y = tzr_pkg::RST_LIGHT_Y;
        light_z = tzr_pkg::RST_LIGHT_Z;
        ambient = tzr_pkg::RST_AMBIENT;
        gain    = tzr_pkg::RST_GAIN;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();          // reset shading values, behind the clear sweep
        test_shading_settings();
        test_backpressure();

        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
